// File: hdl/qslerp_pkg.sv
// Shared constants, types and the arctangent table for the quaternion slerp datapath.
package qslerp_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS   = 29;
    localparam int ISQ_STEPS      = 29;
    localparam int NEAR_WIDTH     = 20;

    localparam logic [16:0] T_ONE = 17'd65536;
    localparam logic [29:0] PI_Q28 = 30'd843314857;
    localparam logic [29:0] HALF_PI_Q28 = 30'd421657428;
    localparam logic [28:0] ONE_Q28 = 29'd268435456;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [NEAR_WIDTH-1:0] NEAR_RESET = 20'd2684;

    localparam logic REG_NEAR_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        MODE_GEN,
        MODE_LIN,
        MODE_OPP
    } mode_t;

    typedef struct packed {
        logic opp;
        logic lin0;
        logic cneg;
    } flag_t;

    function automatic logic [31:0] atan_q28(input int i);
        real r;
        r = $atan(2.0 ** (-i)) * 268435456.0 + 0.5;
        return 32'($rtoi(r));
    endfunction

endpackage

// File: hdl/quaternion_slerp.sv
// Quaternion spherical linear interpolation, fully pipelined.
//
//  port group   | role   | handshake                 | beat
//  pair_*       | input  | pair_valid / pair_stall   | old and new quaternion, blend_t
//  result_*     | output | result_valid/result_stall | out_x..out_w
//  p*           | config | APB, pready tied high     | near_limit at byte address 0
//
// One beat enters per cycle while the pipeline is not held; the depth is set by the
// 29-step square root, two 29-step CORDIC chains and the bit-per-stage divider.
// The whole pipeline holds while the output register is full and stalled.
// Reset clears the valid bits and loads near_limit with its default.
module quaternion_slerp
    import qslerp_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              pair_valid,
    output logic                              pair_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] old_x,
    input  logic signed [COMPONENT_WIDTH-1:0] old_y,
    input  logic signed [COMPONENT_WIDTH-1:0] old_z,
    input  logic signed [COMPONENT_WIDTH-1:0] old_w,
    input  logic signed [COMPONENT_WIDTH-1:0] new_x,
    input  logic signed [COMPONENT_WIDTH-1:0] new_y,
    input  logic signed [COMPONENT_WIDTH-1:0] new_z,
    input  logic signed [COMPONENT_WIDTH-1:0] new_w,
    input  logic [16:0]                       blend_t,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic signed [COMPONENT_WIDTH-1:0] out_w
);

    localparam int W      = COMPONENT_WIDTH;
    localparam int PEXT   = (2 * W > 34) ? 2 * W : 34;
    localparam int FRAC2  = 2 * (W - 2);
    localparam int NW     = W + 34;
    localparam int AW     = 34;
    localparam int S_SQ   = 2;
    localparam int S_REM  = 3;
    localparam int S_ISQ0 = 4;
    localparam int S_AT0  = S_ISQ0 + ISQ_STEPS;
    localparam int S_ACOS = S_AT0 + CORDIC_STEPS;
    localparam int S_ANG  = S_ACOS + 1;
    localparam int S_SIN0 = S_ANG + 2;
    localparam int S_CLMP = S_SIN0 + CORDIC_STEPS;
    localparam int NST    = S_CLMP + 5 + W;

    localparam logic signed [NW-1:0] HI_N = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [NW-1:0] LO_N = ~HI_N;
    localparam logic signed [W-1:0]  HI_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  LO_W = {1'b1, {(W-1){1'b0}}};

    logic                  adv;
    logic [NEAR_WIDTH-1:0] near_reg;
    logic [NST-1:0]        v_reg, v_next;

    logic signed [W-1:0] oin [4];
    logic signed [W-1:0] nin [4];
    logic [16:0]         t_in;

    logic signed [W-1:0] oq_reg  [0:S_CLMP][4];
    logic signed [W-1:0] oq_next [0:S_CLMP][4];
    logic signed [W-1:0] nq_reg  [0:S_CLMP][4];
    logic signed [W-1:0] nq_next [0:S_CLMP][4];
    logic [16:0]         t_reg   [0:S_CLMP];
    logic [16:0]         t_next  [0:S_CLMP];
    flag_t               fl_reg  [0:S_CLMP];
    flag_t               fl_next [0:S_CLMP];

    logic signed [2*W-1:0] prod_reg [4];
    logic signed [2*W-1:0] prod_next [4];
    logic signed [33:0]    scaled [4];
    logic signed [33:0]    dot_reg, dot_next;
    logic signed [35:0]    ppos, pneg, lim36;
    logic signed [33:0]    dabs;
    logic [27:0]           cabs_reg, cabs_next, cab2_reg;
    logic [55:0]           csq_reg, csq_next;
    logic [57:0]           rem_reg, rem_next;

    logic [57:0] iv_reg [ISQ_STEPS], iv_next [ISQ_STEPS];
    logic [57:0] ir_reg [ISQ_STEPS], ir_next [ISQ_STEPS];
    logic [27:0] ic_reg [ISQ_STEPS], ic_next [ISQ_STEPS];

    logic signed [AW-1:0] ax_reg [CORDIC_STEPS], ax_next [CORDIC_STEPS];
    logic signed [AW-1:0] ay_reg [CORDIC_STEPS], ay_next [CORDIC_STEPS];
    logic signed [31:0]   az_reg [CORDIC_STEPS], az_next [CORDIC_STEPS];

    logic signed [33:0] acos_raw;
    logic [29:0]        w_reg, w_next;
    logic [29:0]        wsel;
    logic [16:0]        tm;
    logic [46:0]        pr1, pr2;
    logic [29:0]        g_reg [3], g_next [3];
    logic [29:0]        f_reg [3], f_next [3];

    logic signed [AW-1:0] sx_reg [CORDIC_STEPS][3], sx_next [CORDIC_STEPS][3];
    logic signed [AW-1:0] sy_reg [CORDIC_STEPS][3], sy_next [CORDIC_STEPS][3];
    logic signed [31:0]   sz_reg [CORDIC_STEPS][3], sz_next [CORDIC_STEPS][3];
    logic [30:0]          sn_reg [3], sn_next [3];

    mode_t                 mode_sel;
    logic [30:0]           wa, wb;
    logic signed [W:0]     vsel [4];
    logic signed [W+31:0]  pa_reg [4], pa_next [4];
    logic signed [W+32:0]  pb_reg [4], pb_next [4];
    mode_t                 mm_reg, mm_next;
    logic [30:0]           msn_reg;
    logic signed [W-1:0]   moz_reg;

    logic signed [NW-1:0]  num_reg [4], num_next [4];
    mode_t                 sm_reg;
    logic [30:0]           ssn_reg;
    logic signed [W-1:0]   soz_reg;

    logic [NW-1:0]         dr_reg  [0:W][4], dr_next  [0:W][4];
    logic [W-1:0]          dq_reg  [0:W][4], dq_next  [0:W][4];
    logic                  dneg_reg [0:W][4], dneg_next [0:W][4];
    logic                  dovf_reg [0:W][4], dovf_next [0:W][4];
    logic signed [W-1:0]   dalt_reg [0:W][4], dalt_next [0:W][4];
    mode_t                 dm_reg  [0:W], dm_next  [0:W];
    logic [30:0]           ds_reg  [0:W], ds_next  [0:W];
    logic signed [W-1:0]   doz_reg [0:W], doz_next [0:W];

    logic signed [W-1:0]   out_reg [4], out_next [4];

    assign adv        = !(v_reg[NST-1] && result_stall);
    assign pair_stall = !adv;
    assign result_valid = v_reg[NST-1];
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_NEAR_LIMIT) ? {{(32-NEAR_WIDTH){1'b0}}, near_reg}
                                                     : 32'd0;

    assign oin[0] = old_x;
    assign oin[1] = old_y;
    assign oin[2] = old_z;
    assign oin[3] = old_w;
    assign nin[0] = new_x;
    assign nin[1] = new_y;
    assign nin[2] = new_z;
    assign nin[3] = new_w;
    assign t_in   = (blend_t > T_ONE) ? T_ONE : blend_t;

    assign v_next = {v_reg[NST-2:0], pair_valid};

    // carried operands
    for (genvar k = 0; k <= S_CLMP; k++) begin : g_side
        if (k == 0) begin : g_first
            for (genvar c = 0; c < 4; c++) begin : g_c
                assign oq_next[0][c] = oin[c];
                assign nq_next[0][c] = nin[c];
            end
            assign t_next[0] = t_in;
        end else begin : g_rest
            assign oq_next[k] = oq_reg[k-1];
            assign nq_next[k] = nq_reg[k-1];
            assign t_next[k]  = t_reg[k-1];
        end
        if (k < S_SQ) begin : g_fz
            assign fl_next[k] = '0;
        end else if (k == S_SQ) begin : g_fc
            assign fl_next[k] = '{opp: !(ppos > lim36),
                                  lin0: (ppos > lim36) && !(pneg > lim36),
                                  cneg: dot_reg[33]};
        end else begin : g_fr
            assign fl_next[k] = fl_reg[k-1];
        end
    end

    // dot product
    for (genvar c = 0; c < 4; c++) begin : g_dot
        logic signed [PEXT-1:0] pe;
        assign prod_next[c] = oin[c] * nin[c];
        assign pe = PEXT'(prod_reg[c]);
        if (FRAC2 >= 28) begin : g_dn
            assign scaled[c] = 34'(pe >>> (FRAC2 - 28));
        end else begin : g_up
            assign scaled[c] = 34'(pe <<< (28 - FRAC2));
        end
    end
    assign dot_next = scaled[0] + scaled[1] + scaled[2] + scaled[3];

    assign ppos  = $signed({7'd0, ONE_Q28}) + 36'(dot_reg);
    assign pneg  = $signed({7'd0, ONE_Q28}) - 36'(dot_reg);
    assign lim36 = $signed({{(36-NEAR_WIDTH){1'b0}}, near_reg});
    assign dabs  = dot_reg[33] ? -dot_reg : dot_reg;
    assign cabs_next = dabs[27:0];
    assign csq_next  = 56'(cabs_next) * 56'(cabs_next);
    assign rem_next  = (58'd1 << 56) - 58'(csq_reg);

    // square root, one result bit per stage
    for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
        localparam logic [57:0] B = 58'd1 << (2 * (ISQ_STEPS - 1 - j));
        logic [57:0] vin, rin, sum;
        if (j == 0) begin : g_i0
            assign vin = rem_reg;
            assign rin = '0;
            assign ic_next[0] = cab2_reg;
        end else begin : g_in
            assign vin = iv_reg[j-1];
            assign rin = ir_reg[j-1];
            assign ic_next[j] = ic_reg[j-1];
        end
        assign sum = rin + B;
        assign iv_next[j] = (vin >= sum) ? vin - sum : vin;
        assign ir_next[j] = (vin >= sum) ? (rin >> 1) + B : rin >> 1;
    end

    // arctangent of sqrt(1-c^2) / |c|
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_atan
        localparam logic signed [31:0] A = atan_q28(i);
        logic signed [AW-1:0] xin, yin;
        logic signed [31:0]   zin;
        if (i == 0) begin : g_a0
            assign xin = AW'(ic_reg[ISQ_STEPS-1]);
            assign yin = AW'(ir_reg[ISQ_STEPS-1]);
            assign zin = '0;
        end else begin : g_an
            assign xin = ax_reg[i-1];
            assign yin = ay_reg[i-1];
            assign zin = az_reg[i-1];
        end
        assign ax_next[i] = yin[AW-1] ? xin - (yin >>> i) : xin + (yin >>> i);
        assign ay_next[i] = yin[AW-1] ? yin + (xin >>> i) : yin - (xin >>> i);
        assign az_next[i] = yin[AW-1] ? zin - A : zin + A;
    end

    assign acos_raw = fl_reg[S_ACOS-1].cneg ? 34'(PI_Q28) - 34'(az_reg[CORDIC_STEPS-1])
                                            : 34'(az_reg[CORDIC_STEPS-1]);
    assign w_next = acos_raw[33] ? '0 :
                    (acos_raw > 34'(PI_Q28)) ? PI_Q28 : acos_raw[29:0];

    // sine angles
    assign wsel = fl_reg[S_ACOS].opp ? HALF_PI_Q28 : w_reg;
    assign tm   = T_ONE - t_reg[S_ACOS];
    assign pr1  = 47'(tm) * 47'(wsel);
    assign pr2  = 47'(t_reg[S_ACOS]) * 47'(wsel);
    assign g_next[0] = wsel;
    assign g_next[1] = 30'((pr1 + 47'd32768) >> 16);
    assign g_next[2] = 30'((pr2 + 47'd32768) >> 16);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign f_next[l] = (g_reg[l] > HALF_PI_Q28) ? PI_Q28 - g_reg[l] : g_reg[l];
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin
            localparam logic signed [31:0] A = atan_q28(i);
            logic signed [AW-1:0] xin, yin;
            logic signed [31:0]   zin;
            if (i == 0) begin : g_s0
                assign xin = AW'(GAIN_Q30);
                assign yin = '0;
                assign zin = 32'(f_reg[l]);
            end else begin : g_sn
                assign xin = sx_reg[i-1][l];
                assign yin = sy_reg[i-1][l];
                assign zin = sz_reg[i-1][l];
            end
            assign sx_next[i][l] = zin[31] ? xin + (yin >>> i) : xin - (yin >>> i);
            assign sy_next[i][l] = zin[31] ? yin - (xin >>> i) : yin + (xin >>> i);
            assign sz_next[i][l] = zin[31] ? zin + A : zin - A;
        end
        assign sn_next[l] = sy_reg[CORDIC_STEPS-1][l][AW-1] ? '0 :
                            (sy_reg[CORDIC_STEPS-1][l] > AW'(ONE_Q30)) ? ONE_Q30 :
                            sy_reg[CORDIC_STEPS-1][l][30:0];
    end

    // weights and products
    always_comb
    begin
        if (fl_reg[S_CLMP].opp) begin
            mode_sel = MODE_OPP;
        end else if (fl_reg[S_CLMP].lin0 || sn_reg[0] == '0) begin
            mode_sel = MODE_LIN;
        end else begin
            mode_sel = MODE_GEN;
        end
        case (mode_sel)
            MODE_LIN:
            begin
                wa = 31'(T_ONE - t_reg[S_CLMP]);
                wb = 31'(t_reg[S_CLMP]);
            end
            MODE_OPP:
            begin
                wa = sn_reg[1];
                wb = sn_reg[2];
            end
            default:
            begin
                wa = sn_reg[1];
                wb = sn_reg[2];
            end
        endcase
        if (mode_sel == MODE_OPP) begin
            vsel[0] = -(W+1)'(oq_reg[S_CLMP][1]);
            vsel[1] = (W+1)'(oq_reg[S_CLMP][0]);
            vsel[2] = -(W+1)'(oq_reg[S_CLMP][3]);
            vsel[3] = (W+1)'(nq_reg[S_CLMP][3]);
        end else begin
            for (int c = 0; c < 4; c++) begin
                vsel[c] = (W+1)'(nq_reg[S_CLMP][c]);
            end
        end
    end

    assign mm_next = mode_sel;

    for (genvar c = 0; c < 4; c++) begin : g_post
        logic [NW-1:0]        mag;
        logic signed [NW-1:0] sh;
        logic [W-1:0]         qv;

        assign pa_next[c] = $signed({1'b0, wa}) * oq_reg[S_CLMP][c];
        assign pb_next[c] = $signed({1'b0, wb}) * vsel[c];
        assign num_next[c] = NW'(pa_reg[c]) + NW'(pb_reg[c])
                             + ((mm_reg == MODE_GEN) ? NW'(0) :
                                (mm_reg == MODE_OPP) ? NW'(536870912) : NW'(32768));

        // divider setup and the non-divided results
        assign mag = num_reg[c][NW-1] ? NW'(-num_reg[c]) : NW'(num_reg[c]);
        assign sh  = (sm_reg == MODE_OPP) ? (num_reg[c] >>> 30) : (num_reg[c] >>> 16);
        assign dr_next[0][c]   = mag + NW'(ssn_reg >> 1);
        assign dq_next[0][c]   = '0;
        assign dneg_next[0][c] = num_reg[c][NW-1];
        assign dovf_next[0][c] = (mag + NW'(ssn_reg >> 1)) >= (NW'(ssn_reg) << W);
        assign dalt_next[0][c] = (sh > HI_N) ? HI_W : (sh < LO_N) ? LO_W : sh[W-1:0];

        for (genvar k = 1; k <= W; k++) begin : g_div
            logic [NW-1:0] sub;
            logic          bit_q;
            assign sub   = NW'(ds_reg[k-1]) << (W - k);
            assign bit_q = dr_reg[k-1][c] >= sub;
            assign dr_next[k][c]   = bit_q ? dr_reg[k-1][c] - sub : dr_reg[k-1][c];
            assign dq_next[k][c]   = {dq_reg[k-1][c][W-2:0], bit_q};
            assign dneg_next[k][c] = dneg_reg[k-1][c];
            assign dovf_next[k][c] = dovf_reg[k-1][c];
            assign dalt_next[k][c] = dalt_reg[k-1][c];
        end

        assign qv = dq_reg[W][c];
        always_comb
        begin
            if (dm_reg[W] == MODE_GEN) begin
                if (dovf_reg[W][c]) begin
                    out_next[c] = dneg_reg[W][c] ? LO_W : HI_W;
                end else if (!dneg_reg[W][c]) begin
                    out_next[c] = qv[W-1] ? HI_W : $signed(qv);
                end else begin
                    out_next[c] = (qv[W-1] && |qv[W-2:0]) ? LO_W : -$signed(qv);
                end
            end else if (c == 3 && dm_reg[W] == MODE_OPP) begin
                out_next[c] = doz_reg[W];
            end else begin
                out_next[c] = dalt_reg[W][c];
            end
        end
    end

    assign dm_next[0]  = sm_reg;
    assign ds_next[0]  = ssn_reg;
    assign doz_next[0] = soz_reg;
    for (genvar k = 1; k <= W; k++) begin : g_dcarry
        assign dm_next[k]  = dm_reg[k-1];
        assign ds_next[k]  = ds_reg[k-1];
        assign doz_next[k] = doz_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg    <= '0;
            near_reg <= NEAR_RESET;
        end else begin
            if (adv) begin
                v_reg <= v_next;
            end
            if (psel && penable && pwrite && paddr[2] == REG_NEAR_LIMIT) begin
                near_reg <= pwdata[NEAR_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            oq_reg   <= oq_next;
            nq_reg   <= nq_next;
            t_reg    <= t_next;
            fl_reg   <= fl_next;
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
            cabs_reg <= cabs_next;
            csq_reg  <= csq_next;
            rem_reg  <= rem_next;
            cab2_reg <= cabs_reg;
            iv_reg   <= iv_next;
            ir_reg   <= ir_next;
            ic_reg   <= ic_next;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_reg   <= az_next;
            w_reg    <= w_next;
            g_reg    <= g_next;
            f_reg    <= f_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            sz_reg   <= sz_next;
            sn_reg   <= sn_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            mm_reg   <= mm_next;
            msn_reg  <= sn_reg[0];
            moz_reg  <= oq_reg[S_CLMP][2];
            num_reg  <= num_next;
            sm_reg   <= mm_reg;
            ssn_reg  <= msn_reg;
            soz_reg  <= moz_reg;
            dr_reg   <= dr_next;
            dq_reg   <= dq_next;
            dneg_reg <= dneg_next;
            dovf_reg <= dovf_next;
            dalt_reg <= dalt_next;
            dm_reg   <= dm_next;
            ds_reg   <= ds_next;
            doz_reg  <= doz_next;
            out_reg  <= out_next;
        end
    end

    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign out_w = out_reg[3];

endmodule
